@@ rtl/tdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg: shared types and constants for the tick delay queue scheduler
// holds request and event codes, list sizes and controller/datapath structs
// ----------------------------------------------------------------------------
package tdq_pkg;
	localparam int NumTasks = 16;
	localparam int IdW = 4;
	localparam int CntW = 5;
	localparam int TickW = 32;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_DELAY = 2'd1;
	localparam logic [1:0] REQ_ADD   = 2'd2;

	localparam logic [1:0] EV_WAKE = 2'd0;
	localparam logic [1:0] EV_TICK = 2'd1;
	localparam logic [1:0] EV_CUR  = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_NOCUR = 2'd1;
	localparam logic [1:0] ERR_BAD   = 2'd2;

	localparam logic [1:0] LST_A = 2'd0;
	localparam logic [1:0] LST_B = 2'd1;
	localparam logic [1:0] LST_R = 2'd2;

	typedef struct packed {
		logic            load;      // capture request
		logic            tick_inc;  // advance counter, swap on wrap
		logic            recompute; // next_unblock from list heads
		logic            scan_clr;  // start a list scan
		logic            scan_step; // advance scan index
		logic [1:0]      scan_lst;  // list being scanned
		logic            ins_start; // start sorted insert
		logic            ins_step;  // one shift/compare step
		logic [1:0]      ins_lst;
		logic            ins_delay; // insert current task as delayed
		logic            pop_wake;  // pop normal head into holding reg
		logic            pop_ready; // pop ready head into current
		logic            set_add_wake;
		logic            upd_next;  // delay request next_unblock update
		logic            no_cur;    // clear current after empty switch
		logic            emit;
		logic [1:0]      emit_kind;
		logic [1:0]      emit_err;
		logic            emit_last;
		logic            emit_wake_ref;
	} tdq_cmd_t;

	typedef struct packed {
		logic [1:0]  req;
		logic        cur_valid;
		logic        cur_hit;    // add request names the current task
		logic        tick_wrap;  // counter is zero after an increment
		logic        due;        // normal head due and ready not full
		logic        tick_ge;    // tick >= next_unblock
		logic        scan_done;
		logic        scan_hit;   // id found in scanned list
		logic        ins_done;
		logic        bank_full;  // target delay bank full
		logic        ready_full;
		logic        ready_empty;
		logic        out_busy;
		logic        dly_bank;   // target bank of delay request
	} tdq_sts_t;
endpackage

@@ rtl/tdq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_datapath: tick counter, sorted lists and output register
// a sorted insert shifts a list one entry per cycle; a pop shifts the whole list at once
// ----------------------------------------------------------------------------
module tdq_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tdq_pkg::tdq_cmd_t       cmd,
	output tdq_pkg::tdq_sts_t       sts,
	input  logic [1:0]              req_type,
	input  logic [3:0]              task_id,
	input  logic [31:0]             delay_ticks,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [1:0]              event_kind,
	output logic [3:0]              task_ref,
	output logic                    task_present,
	output logic [31:0]             tick_now,
	output logic [31:0]             next_wake,
	output logic [1:0]              error_code,
	output logic                    last
);
	import tdq_pkg::*;

	logic [TickW-1:0] tick_q, next_q, delay_q, wake_new_q;
	logic [TickW-1:0] wake_q [NumTasks];
	logic [IdW-1:0]   lst_q [3][NumTasks];
	logic [CntW-1:0]  cnt_q [3];
	logic             nbank_q;
	logic [IdW-1:0]   cur_q, id_q, woke_q;
	logic             cur_v_q;
	logic [1:0]       req_q;
	logic [CntW-1:0]  idx_q;
	logic [IdW-1:0]   ins_id_q;
	logic [1:0]       out_kind_q, out_err_q;
	logic [IdW-1:0]   out_ref_q;
	logic             out_pres_q, out_last_q, out_v_q;
	logic [TickW-1:0] out_tick_q, out_next_q;

	logic [1:0]       nl, ol, sl, il;
	logic [TickW-1:0] tick_inc, wake_calc, nxt_calc;
	logic             dly_bank;

	assign nl = nbank_q ? LST_B : LST_A;
	assign ol = nbank_q ? LST_A : LST_B;
	assign sl = cmd.scan_lst;
	assign il = cmd.ins_lst;
	assign tick_inc = tick_q + 1'b1;
	assign wake_calc = tick_q + delay_q;
	assign dly_bank = (wake_calc < tick_q) ? ~nbank_q : nbank_q;

	always_comb begin
		if (cnt_q[nl] != '0)
			nxt_calc = wake_q[lst_q[nl][0]];
		else if (cnt_q[ol] != '0)
			nxt_calc = wake_q[lst_q[ol][0]];
		else
			nxt_calc = '1;
	end

	assign sts.req = req_q;
	assign sts.cur_valid = cur_v_q;
	assign sts.cur_hit = cur_v_q && (cur_q == id_q);
	assign sts.tick_wrap = (tick_q == '0);
	assign sts.due = (cnt_q[nl] != '0) && (wake_q[lst_q[nl][0]] <= tick_q)
		&& (cnt_q[LST_R] < CntW'(NumTasks));
	assign sts.tick_ge = tick_q >= next_q;
	assign sts.scan_done = idx_q >= cnt_q[sl];
	assign sts.scan_hit = (idx_q < cnt_q[sl]) && (lst_q[sl][idx_q[IdW-1:0]] == id_q);
	// insert point found when entry before idx is <= new wake, or idx is 0
	assign sts.ins_done = (idx_q == '0) ||
		(wake_q[lst_q[il][idx_q[IdW-1:0] - 1'b1]] <= wake_q[ins_id_q]);
	assign sts.bank_full = cnt_q[dly_bank ? LST_B : LST_A] >= CntW'(NumTasks);
	assign sts.ready_full = cnt_q[LST_R] >= CntW'(NumTasks);
	assign sts.ready_empty = cnt_q[LST_R] == '0;
	assign sts.out_busy = out_v_q;
	assign sts.dly_bank = dly_bank;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			id_q <= task_id;
			delay_q <= delay_ticks;
		end
		if (cmd.scan_clr) idx_q <= '0;
		else if (cmd.scan_step) idx_q <= idx_q + 1'b1;
		else if (cmd.ins_start) idx_q <= cnt_q[il];
		else if (cmd.ins_step) idx_q <= idx_q - 1'b1;
		if (cmd.set_add_wake) wake_q[id_q] <= tick_q;
		if (cmd.ins_delay) begin
			wake_q[cur_q] <= wake_calc;
			wake_new_q <= wake_calc;
		end
		if (cmd.ins_start) ins_id_q <= cmd.ins_delay ? cur_q :
			(cmd.pop_wake ? lst_q[nl][0] : id_q);
		if (cmd.ins_step) begin
			if (sts.ins_done)
				lst_q[il][idx_q[IdW-1:0]] <= ins_id_q;
			else
				lst_q[il][idx_q[IdW-1:0]] <= lst_q[il][idx_q[IdW-1:0] - 1'b1];
		end
		if (cmd.pop_wake) begin
			woke_q <= lst_q[nl][0];
			for (int i = 0; i < NumTasks - 1; i++) lst_q[nl][i] <= lst_q[nl][i+1];
		end
		if (cmd.pop_ready)
			for (int i = 0; i < NumTasks - 1; i++) lst_q[LST_R][i] <= lst_q[LST_R][i+1];
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_err_q <= cmd.emit_err;
			out_last_q <= cmd.emit_last;
			if (cmd.emit_wake_ref) begin
				out_ref_q <= woke_q;
				out_pres_q <= 1'b1;
			end else begin
				out_ref_q <= cur_v_q ? cur_q : '0;
				out_pres_q <= cur_v_q;
			end
			out_tick_q <= tick_q;
			out_next_q <= next_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			next_q <= '0;
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			cnt_q[2] <= '0;
			nbank_q <= 1'b0;
			cur_q <= '0;
			cur_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.tick_inc) begin
				tick_q <= tick_inc;
				if (tick_inc == '0) nbank_q <= ~nbank_q;
			end
			if (cmd.recompute) next_q <= nxt_calc;
			if (cmd.upd_next && (next_q == '0 || wake_new_q < next_q))
				next_q <= wake_new_q;
			if (cmd.ins_delay) cnt_q[dly_bank ? LST_B : LST_A] <=
				cnt_q[dly_bank ? LST_B : LST_A] + 1'b1;
			if (cmd.pop_wake) begin
				cnt_q[nl] <= cnt_q[nl] - 1'b1;
				cnt_q[LST_R] <= cnt_q[LST_R] + 1'b1;
			end
			if (cmd.set_add_wake) cnt_q[LST_R] <= cnt_q[LST_R] + 1'b1;
			if (cmd.ins_delay) cur_v_q <= cur_v_q;
			if (cmd.pop_ready) begin
				cur_q <= lst_q[LST_R][0];
				cur_v_q <= 1'b1;
				cnt_q[LST_R] <= cnt_q[LST_R] - 1'b1;
			end
			if (cmd.no_cur) begin
				cur_q <= '0;
				cur_v_q <= 1'b0;
			end
			if (cmd.emit) out_v_q <= 1'b1;
			else if (!out_stall) out_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign event_kind = out_kind_q;
	assign task_ref = out_ref_q;
	assign task_present = out_pres_q;
	assign tick_now = out_tick_q;
	assign next_wake = out_next_q;
	assign error_code = out_err_q;
	assign last = out_last_q;
endmodule

@@ rtl/tdq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_ctrl: request sequencer
// steps scans, sorted inserts and wake pops; emits one event per result
// ----------------------------------------------------------------------------
module tdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tdq_pkg::tdq_sts_t sts,
	output tdq_pkg::tdq_cmd_t cmd
);
	import tdq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_TWAKE  = 4'd2;
	localparam logic [3:0] S_TINS   = 4'd3;
	localparam logic [3:0] S_TSUM   = 4'd4;
	localparam logic [3:0] S_DINS   = 4'd5;
	localparam logic [3:0] S_DSW    = 4'd6;
	localparam logic [3:0] S_SCAN   = 4'd7;
	localparam logic [3:0] S_AINS   = 4'd8;
	localparam logic [3:0] S_ACUR   = 4'd9;
	localparam logic [3:0] S_EMIT   = 4'd10;
	localparam logic [3:0] S_TNEXT  = 4'd11;
	localparam logic [3:0] S_TCHK   = 4'd12;

	logic [3:0] st_q, st_d;
	logic [1:0] lst_q, lst_d;
	logic [1:0] err_q, err_d;
	logic       bnk_q, bnk_d;

	assign in_stall = (st_q != S_IDLE);

	always_comb begin
		cmd = '0;
		st_d = st_q;
		lst_d = lst_q;
		err_d = err_q;
		bnk_d = bnk_q;
		cmd.scan_lst = lst_q;
		cmd.ins_lst = LST_R;
		unique case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d = S_DEC;
				end
			end
			S_DEC: begin
				case (sts.req)
					REQ_TICK: begin
						cmd.tick_inc = 1'b1;
						st_d = S_TCHK;
					end
					REQ_DELAY: begin
						if (!sts.cur_valid) begin
							err_d = ERR_NOCUR;
							st_d = S_EMIT;
						end else if (sts.bank_full) begin
							err_d = ERR_BAD;
							st_d = S_EMIT;
						end else begin
							cmd.ins_delay = 1'b1;
							cmd.ins_start = 1'b1;
							cmd.ins_lst = sts.dly_bank ? LST_B : LST_A;
							bnk_d = sts.dly_bank;
							st_d = S_DINS;
						end
					end
					REQ_ADD: begin
						err_d = ERR_OK;
						lst_d = LST_A;
						cmd.scan_clr = 1'b1;
						st_d = S_SCAN;
					end
					default: st_d = S_IDLE;
				endcase
			end
			S_TCHK: begin
				if (sts.tick_wrap) cmd.recompute = 1'b1;
				st_d = S_TNEXT;
			end
			S_TNEXT: begin
				st_d = sts.tick_ge ? S_TWAKE : S_TSUM;
			end
			S_TWAKE: begin
				if (sts.out_busy) begin
				end else if (sts.due) begin
					cmd.pop_wake = 1'b1;
					cmd.ins_start = 1'b1;
					st_d = S_TINS;
				end else begin
					cmd.recompute = 1'b1;
					st_d = S_TSUM;
				end
			end
			S_TINS: begin
				cmd.ins_step = 1'b1;
				if (sts.ins_done) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = EV_WAKE;
					cmd.emit_wake_ref = 1'b1;
					st_d = S_TWAKE;
				end
			end
			S_TSUM: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = EV_TICK;
					cmd.emit_last = 1'b1;
					st_d = S_IDLE;
				end
			end
			S_DINS: begin
				cmd.ins_lst = bnk_q ? LST_B : LST_A;
				cmd.ins_step = 1'b1;
				if (sts.ins_done) begin
					cmd.upd_next = 1'b1;
					st_d = S_DSW;
				end
			end
			S_DSW: begin
				if (sts.ready_empty) cmd.no_cur = 1'b1;
				else cmd.pop_ready = 1'b1;
				err_d = ERR_OK;
				st_d = S_EMIT;
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					err_d = ERR_BAD;
					st_d = S_EMIT;
				end else if (sts.scan_done) begin
					if (lst_q == LST_R) begin
						if (sts.ready_full || sts.cur_hit) begin
							err_d = ERR_BAD;
							st_d = S_EMIT;
						end else begin
							cmd.set_add_wake = 1'b1;
							cmd.ins_start = 1'b1;
							st_d = S_AINS;
						end
					end else begin
						lst_d = lst_q + 1'b1;
						cmd.scan_clr = 1'b1;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_AINS: begin
				cmd.ins_step = 1'b1;
				if (sts.ins_done) st_d = S_ACUR;
			end
			S_ACUR: begin
				if (!sts.cur_valid) cmd.pop_ready = 1'b1;
				st_d = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = EV_CUR;
					cmd.emit_err = err_q;
					cmd.emit_last = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			lst_q <= LST_A;
			err_q <= ERR_OK;
			bnk_q <= 1'b0;
		end else begin
			st_q <= st_d;
			lst_q <= lst_d;
			err_q <= err_d;
			bnk_q <= bnk_d;
		end
	end
endmodule

@@ rtl/tick_delay_queue_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_delay_queue_scheduler: hardware task delay engine
// tick counter, two sorted delay lists, ready list and current task
// ----------------------------------------------------------------------------
// usage
// - request channel: in_valid/in_stall with req_type, task_id, delay_ticks
//   req_type tick, delay current task, or add task; code 3 gives no result
// - result channel: out_valid/out_stall with the event fields; last marks
//   the final result of a request
// - one request at a time: a tick does a sorted insert per woken task
//   (sorted insert walks the ready list one entry a cycle); add does a
//   membership scan of the three lists, one entry per cycle
// - the sequencer waits while the single output register is still full,
//   so a stalled receiver simply holds the engine
// - reset clears the counter, list counts and the current task; list
//   entries are never read before they are written
// ----------------------------------------------------------------------------
module tick_delay_queue_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  task_id,
	input  logic [31:0] delay_ticks,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [3:0]  task_ref,
	output logic        task_present,
	output logic [31:0] tick_now,
	output logic [31:0] next_wake,
	output logic [1:0]  error_code,
	output logic        last
);
	import tdq_pkg::*;

	tdq_cmd_t cmd;
	tdq_sts_t sts;

	// sequencer: one request in flight
	tdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// lists, counter and output register
	tdq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.task_id      (task_id),
		.delay_ticks  (delay_ticks),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.event_kind   (event_kind),
		.task_ref     (task_ref),
		.task_present (task_present),
		.tick_now     (tick_now),
		.next_wake    (next_wake),
		.error_code   (error_code),
		.last         (last)
	);
endmodule

@@ rtl/tdq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_checker: port-level checks for the scheduler
// watches the result channel and request flow control
// ----------------------------------------------------------------------------
module tdq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  event_kind,
	input logic        task_present,
	input logic [3:0]  task_ref,
	input logic [1:0]  error_code,
	input logic        last
);
	import tdq_pkg::*;

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind))
		else $error("stalled result changed");

	a_no_ref: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !task_present |-> task_ref == '0)
		else $error("absent task with nonzero ref");

	a_wake_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == EV_WAKE |-> !last)
		else $error("wake event marked last");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |-> event_kind == EV_CUR)
		else $error("error on non-request event");
endmodule

bind tick_delay_queue_scheduler tdq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
	.task_present(task_present), .task_ref(task_ref),
	.error_code(error_code), .last(last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tick_delay_queue_scheduler
// drives tick, delay and add requests under several idle/stall mixes and a
// long receiver hold-off; an in-bench task scheduler predicts every event
// and a monitor compares each accepted result field by field
// ----------------------------------------------------------------------------
module testbench;
	import tdq_pkg::*;

	localparam int  LimitCycles = 400000;
	localparam int  DrainCycles = 200;
	localparam logic [1:0] REQ_NONE = 2'd3;   // unused code, block ignores it
	localparam int  BankA = 0, BankB = 1, RdyL = 2;

	// expected event as the block should present it
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  ref_id;
		logic        present;
		logic [31:0] tick;
		logic [31:0] nxt;
		logic [1:0]  err;
		logic        fin;
	} sched_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_TICK;
	logic [3:0]  task_id = '0;
	logic [31:0] delay_ticks = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [3:0]  task_ref;
	logic        task_present;
	logic [31:0] tick_now;
	logic [31:0] next_wake;
	logic [1:0]  error_code;
	logic        last;

	tick_delay_queue_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .task_id(task_id), .delay_ticks(delay_ticks),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_kind(event_kind), .task_ref(task_ref), .task_present(task_present),
		.tick_now(tick_now), .next_wake(next_wake), .error_code(error_code),
		.last(last)
	);

	// scheduler shadow state
	logic [31:0] tick_cnt, next_ub;
	logic [31:0] wake_at [NumTasks];
	logic [3:0]  lists [3][NumTasks];   // bank a, bank b, ready list
	int          cnt [3];
	int          norm_bank;
	logic [3:0]  cur;
	logic        cur_ok;

	sched_event_t pending_events[$];
	int          errs = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycle counter doubles as the watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LimitCycles) begin
			$display("timeout after %0d cycles", cycles);
			$display("** tick_delay_queue_scheduler: FAILED **");
			$finish;
		end
	end

	// receiver: random stall, or a long forced hold-off when requested
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch @%0t: %s got %h expected %h", $realtime, what, got, want);
		errs++;
	endtask

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic void list_insert(int l, logic [3:0] id);
		int pos;
		pos = 0;
		while (pos < cnt[l] && wake_at[lists[l][pos]] <= wake_at[id])
			pos++;
		for (int i = cnt[l]; i > pos; i--)
			lists[l][i] = lists[l][i-1];
		lists[l][pos] = id;
		cnt[l]++;
	endfunction

	function automatic logic [3:0] list_pop(int l);
		logic [3:0] id;
		id = lists[l][0];
		for (int i = 0; i < cnt[l] - 1; i++)
			lists[l][i] = lists[l][i+1];
		cnt[l]--;
		return id;
	endfunction

	function automatic bit list_has(int l, logic [3:0] id);
		for (int i = 0; i < cnt[l]; i++)
			if (lists[l][i] == id)
				return 1'b1;
		return 1'b0;
	endfunction

	// next unblock: normal head, else overflow head, else all ones
	function automatic void refresh_next_ub();
		if (cnt[norm_bank] > 0)
			next_ub = wake_at[lists[norm_bank][0]];
		else if (cnt[norm_bank ^ 1] > 0)
			next_ub = wake_at[lists[norm_bank ^ 1][0]];
		else
			next_ub = '1;
	endfunction

	function automatic void push_event(logic [1:0] kind, logic present, logic [3:0] id,
			logic [1:0] err);
		sched_event_t e;
		e.kind = kind;
		e.present = present;
		e.ref_id = present ? id : 4'd0;
		e.tick = tick_cnt;
		e.nxt = next_ub;
		e.err = err;
		e.fin = (kind != EV_WAKE);
		pending_events.push_back(e);
	endfunction

	function automatic void promote_ready_head();
		if (cnt[RdyL] > 0) begin
			cur = list_pop(RdyL);
			cur_ok = 1'b1;
		end else begin
			cur = '0;
			cur_ok = 1'b0;
		end
	endfunction

	function automatic void predict_request(logic [1:0] rt, logic [3:0] id, logic [31:0] d);
		logic [31:0] wake;
		int bank;
		logic [3:0] woke;
		case (rt)
			REQ_TICK: begin
				tick_cnt = tick_cnt + 1;
				if (tick_cnt == 0) begin
					norm_bank ^= 1;
					refresh_next_ub();
				end
				if (tick_cnt >= next_ub) begin
					// wake cap equals the task count, so it never binds
					while (cnt[norm_bank] > 0 && wake_at[lists[norm_bank][0]] <= tick_cnt
							&& cnt[RdyL] < NumTasks) begin
						woke = list_pop(norm_bank);
						list_insert(RdyL, woke);
						push_event(EV_WAKE, 1'b1, woke, ERR_OK);
					end
					refresh_next_ub();
				end
				push_event(EV_TICK, cur_ok, cur, ERR_OK);
			end
			REQ_DELAY: begin
				if (!cur_ok) begin
					push_event(EV_CUR, 1'b0, 4'd0, ERR_NOCUR);
				end else begin
					wake = tick_cnt + d;
					bank = (wake < tick_cnt) ? (norm_bank ^ 1) : norm_bank;
					if (cnt[bank] >= NumTasks) begin
						push_event(EV_CUR, cur_ok, cur, ERR_BAD);
					end else begin
						wake_at[cur] = wake;
						list_insert(bank, cur);
						if (next_ub == 0 || wake < next_ub)
							next_ub = wake;
						promote_ready_head();
						push_event(EV_CUR, cur_ok, cur, ERR_OK);
					end
				end
			end
			REQ_ADD: begin
				if (cnt[RdyL] >= NumTasks || (cur_ok && cur == id) || list_has(RdyL, id)
						|| list_has(BankA, id) || list_has(BankB, id)) begin
					push_event(EV_CUR, cur_ok, cur, ERR_BAD);
				end else begin
					wake_at[id] = tick_cnt;
					list_insert(RdyL, id);
					if (!cur_ok)
						promote_ready_head();
					push_event(EV_CUR, cur_ok, cur, ERR_OK);
				end
			end
			default: ;   // ignored code, no event
		endcase
	endfunction

	// ------------------------------------------------------------------
	// request driver: called at a falling edge, returns at a falling edge
	// ------------------------------------------------------------------
	task automatic send_request(input logic [1:0] rt, input logic [3:0] id,
			input logic [31:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		task_id <= id;
		delay_ticks <= d;
		// wait for the request to be taken
		do
			@(posedge clk);
		while (in_stall);
		predict_request(rt, id, d);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	always @(posedge clk) begin
		sched_event_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				report_mismatch("unexpected result, event_kind", 32'(event_kind), 32'd0);
			end else begin
				e = pending_events.pop_front();
				check_field("event_kind", 32'(event_kind), 32'(e.kind));
				check_field("task_ref", 32'(task_ref), 32'(e.ref_id));
				check_field("task_present", 32'(task_present), 32'(e.present));
				check_field("tick_now", tick_now, e.tick);
				check_field("next_wake", next_wake, e.nxt);
				check_field("error_code", 32'(error_code), 32'(e.err));
				check_field("last", 32'(last), 32'(e.fin));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// reset corner, missing current task, duplicate add, equal wake times,
	// zero and maximal delays, overflow filing and the ignored code
	task automatic test_directed();
		send_request(REQ_TICK, 4'd0, 32'd0);        // tick with empty lists
		send_request(REQ_DELAY, 4'd0, 32'd5);       // no current task
		send_request(REQ_ADD, 4'd5, 32'd0);         // becomes current
		send_request(REQ_ADD, 4'd5, 32'd0);         // already current
		send_request(REQ_ADD, 4'd0, 32'd0);
		send_request(REQ_ADD, 4'd15, 32'd0);
		send_request(REQ_ADD, 4'd0, 32'd0);         // already ready
		send_request(REQ_DELAY, 4'd0, 32'd0);       // zero delay
		send_request(REQ_TICK, 4'd0, 32'd0);        // wakes it
		send_request(REQ_DELAY, 4'd0, 32'd3);
		send_request(REQ_DELAY, 4'd0, 32'd3);       // same wake time, fifo order
		send_request(REQ_ADD, 4'd15, 32'd0);        // already delayed
		send_request(REQ_NONE, 4'd9, 32'hFFFF_FFFF);// ignored
		repeat (4)
			send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_DELAY, 4'd0, 32'hFFFF_FFFF); // wraps onto overflow list
		send_request(REQ_ADD, 4'd10, 32'd0);
		send_request(REQ_DELAY, 4'd0, 32'h8000_0000);
		send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_ADD, 4'd3, 32'd0);
		send_request(REQ_DELAY, 4'd0, 32'd1);
		send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_TICK, 4'd0, 32'd0);
	endtask

	// mostly ticks and short delays so tasks cycle; rare huge delays
	task automatic test_random(input int n, input int idle_pct, input int stall_pct);
		int r, k;
		logic [31:0] d;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		k = 0;
		while (k < n) begin
			r = $urandom_range(99);
			if (r < 45) begin
				send_request(REQ_TICK, 4'($urandom), 32'($urandom));
				k++;
			end else if (r < 72) begin
				r = $urandom_range(99);
				if (r < 65)
					d = $urandom_range(8);
				else if (r < 92)
					d = $urandom_range(40, 9);
				else if (r < 96)
					d = $urandom;
				else
					d = 32'hFFFF_FFFF - $urandom_range(6);
				send_request(REQ_DELAY, 4'($urandom), d);
				k++;
			end else if (r < 96) begin
				send_request(REQ_ADD, 4'($urandom_range(15)), 32'($urandom));
				k++;
			end else begin
				send_request(REQ_NONE, 4'($urandom), 32'($urandom));
			end
		end
	endtask

	// receiver holds off long enough that the block backs up onto its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 300;
		repeat (6) begin
			send_request(REQ_TICK, 4'd0, 32'd0);
			send_request(REQ_DELAY, 4'd0, 32'($urandom_range(3)));
		end
	endtask

	task automatic wait_drain();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (pending_events.size() != 0 && n < 20000) begin
			@(negedge clk);
			n++;
		end
		repeat (DrainCycles)
			@(negedge clk);
	endtask

	initial begin
		tick_cnt = '0;
		next_ub = '0;
		cnt[BankA] = 0;
		cnt[BankB] = 0;
		cnt[RdyL] = 0;
		norm_bank = 0;
		cur = '0;
		cur_ok = 1'b0;
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(20, 0, 0);
		test_random(25, 58, 0);
		test_random(25, 0, 58);
		test_random(25, 28, 28);
		test_backpressure();
		recv_stall_pct = 0;
		wait_drain();

		if (errs == 0 && pending_events.size() == 0)
			$display("** tick_delay_queue_scheduler: PASSED **");
		else begin
			if (pending_events.size() != 0)
				$display("%0d expected results never arrived", pending_events.size());
			$display("** tick_delay_queue_scheduler: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tdq_pkg.sv
rtl/tdq_datapath.sv
rtl/tdq_ctrl.sv
rtl/tick_delay_queue_scheduler.sv
rtl/tdq_checker.sv
tb/testbench.sv
